// File: design/bcc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button click classifier.
// No dependencies; every other file of the block imports this package.
package bcc_pkg;

   localparam int MODE_W       = 4;
   localparam int TICKS_W      = 16;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 16;
   localparam int TIMER_W_DEF  = 16;

   localparam logic [MODE_W-1:0] MODE_IDLE         = 4'd0;
   localparam logic [MODE_W-1:0] MODE_DEBOUNCE     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_PRESSED      = 4'd2;
   localparam logic [MODE_W-1:0] MODE_CLICK_UP     = 4'd3;
   localparam logic [MODE_W-1:0] MODE_CLICK_IDLE   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_SINGLE       = 4'd5;
   localparam logic [MODE_W-1:0] MODE_DBL_DEBOUNCE = 4'd6;
   localparam logic [MODE_W-1:0] MODE_DOUBLE       = 4'd7;
   localparam logic [MODE_W-1:0] MODE_LONG         = 4'd8;
   localparam logic [MODE_W-1:0] MODE_OTHER_UP     = 4'd9;

   localparam logic [CSR_IDX_W-1:0] REG_PRESS_LEVEL  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SINGLE_CLICK = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS   = 8'd3;

   localparam logic [TICKS_W-1:0] DEBOUNCE_RST     = 16'd50;
   localparam logic [TICKS_W-1:0] SINGLE_CLICK_RST = 16'd300;
   localparam logic [TICKS_W-1:0] LONG_PRESS_RST   = 16'd1000;

   typedef struct packed {
      logic               press_level;
      logic [TICKS_W-1:0] debounce_ticks;
      logic [TICKS_W-1:0] single_click_ticks;
      logic [TICKS_W-1:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic pin_level;
   } req_word_type;

   typedef struct packed {
      logic              press_event;
      logic              single_click;
      logic              double_click;
      logic              long_hold;
      logic              release_event;
      logic [MODE_W-1:0] current_mode;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] wdata;
   } csr_word_type;

endpackage

// File: design/bcc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the button click classifier.
// Depends on bcc_pkg for the word types.
interface bcc_req_if import bcc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bcc_rsp_if import bcc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bcc_csr_if import bcc_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: design/bcc_fsm.sv
`timescale 1ns / 1ps
// Next-state logic of the click state machine: saturating tick timer,
// threshold compares and one-tick event flags. Depends on bcc_pkg.
module bcc_fsm import bcc_pkg::*; #(
   parameter int TIMER_WIDTH = TIMER_W_DEF
) (
   input  logic                   pin_level,
   input  cfg_type                cfg,
   input  logic [MODE_W-1:0]      mode,
   input  logic [TIMER_WIDTH-1:0] elapsed,
   output logic [MODE_W-1:0]      mode_next,
   output logic [TIMER_WIDTH-1:0] elapsed_next,
   output logic                   entered,
   output rsp_word_type           word
);

   localparam int CmpWidth = (TIMER_WIDTH > TICKS_W) ? TIMER_WIDTH : TICKS_W;

   logic                   pressed;
   logic [TIMER_WIDTH-1:0] t_inc;
   logic [CmpWidth-1:0]    t_cmp;
   logic                   deb_hit;
   logic                   single_hit;
   logic                   long_hit;
   logic [MODE_W-1:0]      cand;

   assign pressed    = cfg.press_level ? pin_level : ~pin_level;
   assign t_inc      = (&elapsed) ? elapsed : elapsed + TIMER_WIDTH'(1);
   assign t_cmp      = CmpWidth'(t_inc);
   assign deb_hit    = t_cmp >= CmpWidth'(cfg.debounce_ticks);
   assign single_hit = t_cmp >= CmpWidth'(cfg.single_click_ticks);
   assign long_hit   = t_cmp >= CmpWidth'(cfg.long_press_ticks);

   always_comb begin
      unique case (mode)
         MODE_IDLE:         cand = pressed ? MODE_DEBOUNCE : MODE_IDLE;
         MODE_DEBOUNCE:     cand = !pressed ? MODE_IDLE :
                                   (deb_hit ? MODE_PRESSED : MODE_DEBOUNCE);
         MODE_PRESSED:      cand = !pressed ? MODE_CLICK_UP :
                                   (long_hit ? MODE_LONG : MODE_PRESSED);
         MODE_CLICK_UP:     cand = MODE_CLICK_IDLE;
         MODE_CLICK_IDLE:   cand = pressed ? MODE_DBL_DEBOUNCE :
                                   (single_hit ? MODE_SINGLE : MODE_CLICK_IDLE);
         MODE_SINGLE:       cand = MODE_IDLE;
         MODE_DBL_DEBOUNCE: cand = !pressed ? MODE_CLICK_IDLE :
                                   (deb_hit ? MODE_DOUBLE : MODE_DBL_DEBOUNCE);
         MODE_DOUBLE:       cand = pressed ? MODE_DOUBLE : MODE_OTHER_UP;
         MODE_LONG:         cand = pressed ? MODE_LONG : MODE_OTHER_UP;
         MODE_OTHER_UP:     cand = MODE_IDLE;
         default:           cand = MODE_IDLE;
      endcase
   end

   always_comb begin
      if (!pressed && mode == MODE_IDLE) begin
         mode_next    = mode;
         elapsed_next = '0;
         entered      = 1'b0;
      end else if (cand != mode) begin
         mode_next    = cand;
         elapsed_next = '0;
         entered      = 1'b1;
      end else begin
         mode_next    = mode;
         elapsed_next = t_inc;
         entered      = 1'b0;
      end
   end

   always_comb begin
      word.press_event   = entered && (mode_next == MODE_PRESSED ||
                                       mode_next == MODE_DOUBLE);
      word.single_click  = entered && mode_next == MODE_SINGLE;
      word.double_click  = entered && mode_next == MODE_DOUBLE;
      word.long_hold     = entered && mode_next == MODE_LONG;
      word.release_event = entered && (mode_next == MODE_SINGLE ||
                                       mode_next == MODE_OTHER_UP);
      word.current_mode  = mode_next;
   end

endmodule

// File: design/button_click_classifier.sv
`timescale 1ns / 1ps
// Button click classifier top level: configuration registers, click state
// and result register. Depends on bcc_pkg, bcc_if and bcc_fsm.
//
// Usage:
//   req_if carries one word per system tick with the raw pin level.
//   rsp_if returns one word per request word: press, single click, double
//   click, long hold and release flags, plus the mode after that tick.
//   csr_if writes the polarity and the three tick thresholds by index;
//   writes are always taken and apply from the next request word on.
// Latency: a result word is valid the cycle after its request word is
//   accepted. Throughput: one word per cycle unless rsp_if stalls; the state
//   update between state and result registers is combinational.
// Reset: thresholds return to 50, 300 and 1000 ticks, polarity to active
//   low, the mode to idle, the timer to zero and the result register empty.
// Stall: while a result word waits on rsp_if, req_if.ready stays high only
//   if the receiver takes that word in the same cycle; the click state
//   advances only on accepted request words.
module button_click_classifier import bcc_pkg::*; #(
   parameter int TIMER_WIDTH = TIMER_W_DEF
) (
   input logic    clock,
   input logic    reset,
   bcc_req_if.sink   req_if,
   bcc_rsp_if.source rsp_if,
   bcc_csr_if.sink   csr_if
);

   cfg_type                cfg_ff, cfg_in;
   logic [MODE_W-1:0]      mode_ff, mode_in;
   logic [TIMER_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;
   logic [MODE_W-1:0]      mode_next;
   logic [TIMER_WIDTH-1:0] elapsed_next;
   logic                   entered;
   rsp_word_type           word;
   logic                   accept;
   logic                   csr_write;

   assign req_if.ready   = !rsp_valid_ff || rsp_if.ready;
   assign accept         = req_if.valid && req_if.ready;
   assign csr_if.ready   = 1'b1;
   assign csr_write      = csr_if.valid && csr_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_word_ff;

   bcc_fsm #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_fsm (
      .pin_level    (req_if.payload.pin_level),
      .cfg          (cfg_ff),
      .mode         (mode_ff),
      .elapsed      (elapsed_ff),
      .mode_next    (mode_next),
      .elapsed_next (elapsed_next),
      .entered      (entered),
      .word         (word)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_if.payload.reg_index)
            REG_PRESS_LEVEL:  cfg_in.press_level = csr_if.payload.wdata[0];
            REG_DEBOUNCE:     cfg_in.debounce_ticks = TICKS_W'(csr_if.payload.wdata);
            REG_SINGLE_CLICK: cfg_in.single_click_ticks = TICKS_W'(csr_if.payload.wdata);
            REG_LONG_PRESS:   cfg_in.long_press_ticks = TICKS_W'(csr_if.payload.wdata);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   assign mode_in      = accept ? mode_next : mode_ff;
   assign elapsed_in   = accept ? elapsed_next : elapsed_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_word_in  = accept ? word : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_level        <= 1'b0;
         cfg_ff.debounce_ticks     <= DEBOUNCE_RST;
         cfg_ff.single_click_ticks <= SINGLE_CLICK_RST;
         cfg_ff.long_press_ticks   <= LONG_PRESS_RST;
         mode_ff                   <= MODE_IDLE;
         elapsed_ff                <= '0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         mode_ff      <= mode_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   a_mode_in_range: assert property (@(posedge clock) disable iff (reset)
      mode_ff <= MODE_OTHER_UP)
      else $error("click mode left the legal range");

   a_entry_clears_timer: assert property (@(posedge clock) disable iff (reset)
      (accept && entered) |=> (elapsed_ff == '0))
      else $error("timer not cleared on state entry");

   a_result_tracks_mode: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_word_ff.current_mode == mode_ff))
      else $error("result mode differs from state");

   a_double_is_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.double_click) |-> rsp_word_ff.press_event)
      else $error("double click without press flag");

endmodule
